/* rtl/mte_pkg.sv */
// Package for the multinomial term enumerator: widths, limits and the factorial table.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mte_pkg;
   localparam int DefMaxVars  = 4;
   localparam int DefMaxPower = 15;
   localparam int CoefW       = 24;
   localparam int ExpW        = 16;
   localparam int PartW       = 5;
   localparam int FactW       = 64;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_NEXT  = 1'b1;

   function automatic logic [FactW-1:0] fact_value(input logic [PartW-1:0] k);
      logic [FactW-1:0] r;
      case (k)
         5'd0:    r = 64'd1;
         5'd1:    r = 64'd1;
         5'd2:    r = 64'd2;
         5'd3:    r = 64'd6;
         5'd4:    r = 64'd24;
         5'd5:    r = 64'd120;
         5'd6:    r = 64'd720;
         5'd7:    r = 64'd5040;
         5'd8:    r = 64'd40320;
         5'd9:    r = 64'd362880;
         5'd10:   r = 64'd3628800;
         5'd11:   r = 64'd39916800;
         5'd12:   r = 64'd479001600;
         5'd13:   r = 64'd6227020800;
         5'd14:   r = 64'd87178291200;
         5'd15:   r = 64'd1307674368000;
         5'd16:   r = 64'd20922789888000;
         5'd17:   r = 64'd355687428096000;
         5'd18:   r = 64'd6402373705728000;
         5'd19:   r = 64'd121645100408832000;
         5'd20:   r = 64'd2432902008176640000;
         default: r = 64'd1;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

/* rtl/multinomial_term_enumerator.sv */
// Top level of the multinomial term enumerator: sequencer, term state, output register.
// Depends on mte_pkg and mte_divider.
//
//   channel  direction  handshake              payload
//   req      in         req_valid, req_stall   req_cmd, req_power
//   rsp      out        rsp_valid, rsp_stall   rsp_valid_res, rsp_coefficient,
//                                              rsp_exponents, rsp_last
//   csr      in         csr_write              csr_data
//
// A next transaction after the end of the expansion gives its result in the next cycle.
// A next transaction within one partition steps through the find, swap and reverse states.
// Loading a partition runs the shared divider once per variable, each pass removing one
// factorial; a start loads the first partition and steps to the next term before it answers.
// Reset is synchronous. A new transaction is taken only in idle and once the result
// register is free.
`default_nettype none
module multinomial_term_enumerator
   import mte_pkg::*;
#(
   parameter int MAX_VARS  = DefMaxVars,
   parameter int MAX_POWER = DefMaxPower
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_cmd,
   input  wire logic [3:0]       req_power,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid_res,
   output logic [CoefW-1:0]      rsp_coefficient,
   output logic [ExpW-1:0]       rsp_exponents,
   output logic                  rsp_last,
   input  wire logic             csr_write,
   input  wire logic [2:0]       csr_data
);
   localparam int IW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int NW = $clog2(MAX_VARS + 1);
   localparam int PW = PartW + IW + 1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FIND  = 7'b0000010,
      S_SWAP  = 7'b0000100,
      S_REV   = 7'b0001000,
      S_PART  = 7'b0010000,
      S_LOAD  = 7'b0100000,
      S_DIV   = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [PartW-1:0] part_ff [MAX_VARS], part_in [MAX_VARS];
   logic [PartW-1:0] perm_ff [MAX_VARS], perm_in [MAX_VARS];
   logic [NW-1:0]    nv_ff, nv_in;
   logic [PartW-1:0] tp_ff, tp_in;
   logic             fin_ff, fin_in;
   logic             first_ff, first_in;
   logic [FactW-1:0] coef_ff, coef_in;
   logic [IW-1:0]    i_ff, i_in, j_ff, j_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [PartW-1:0] rest_ff, rest_in;
   logic             out_v_ff, out_v_in, res_ff, res_in, last_ff, last_in;
   logic [CoefW-1:0] ocoef_ff, ocoef_in;
   logic [ExpW-1:0]  oexp_ff, oexp_in;
   logic [CoefW-1:0] pcoef_ff, pcoef_in;
   logic [ExpW-1:0]  pexp_ff, pexp_in;
   logic [ExpW-1:0]  cur_exp;
   logic             dv_start, dv_busy;
   logic [FactW-1:0] dv_quo, dv_dvd, dv_dvs;
   logic [PartW-1:0] p_sat, v, r, take;
   logic [IW-1:0]    last_idx, span;
   logic [PW-1:0]    prod;
   logic [NW-1:0]    nv_sat;

   mte_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_dvd),
      .divisor(dv_dvs), .busy(dv_busy), .quotient(dv_quo)
   );

   assign req_stall       = (state_ff != S_IDLE) || (out_v_ff && rsp_stall);
   assign rsp_valid       = out_v_ff;
   assign rsp_valid_res   = res_ff;
   assign rsp_coefficient = ocoef_ff;
   assign rsp_exponents   = oexp_ff;
   assign rsp_last        = last_ff;

   assign last_idx = IW'(nv_ff - NW'(1));
   assign span     = last_idx - j_ff;

   always_comb begin
      state_in = state_ff;
      part_in  = part_ff;
      perm_in  = perm_ff;
      nv_in    = nv_ff;
      tp_in    = tp_ff;
      fin_in   = fin_ff;
      first_in = first_ff;
      coef_in  = coef_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      rest_in  = rest_ff;
      out_v_in = out_v_ff && rsp_stall;
      res_in   = res_ff;
      last_in  = last_ff;
      ocoef_in = ocoef_ff;
      oexp_in  = oexp_ff;
      pcoef_in = pcoef_ff;
      pexp_in  = pexp_ff;
      dv_start = 1'b0;
      dv_dvd   = coef_ff;
      dv_dvs   = fact_value(part_ff[i_ff]);
      p_sat    = (int'(req_power) > MAX_POWER) ? PartW'(MAX_POWER) : PartW'(req_power);
      v        = part_ff[j_ff] - PartW'(1);
      r        = rest_ff + PartW'(1);
      take     = '0;
      prod     = PW'(v) * PW'(span);

      cur_exp = '0;
      for (int k = 0; k < MAX_VARS && k < 4; k++) begin
         if (k < int'(nv_ff)) begin
            cur_exp[4*k +: 4] = perm_ff[k][3:0];
         end
      end

      if (csr_data < 3'd2) begin
         nv_sat = NW'(2);
      end else if (int'(csr_data) > MAX_VARS) begin
         nv_sat = NW'(MAX_VARS);
      end else begin
         nv_sat = NW'(csr_data);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               if (req_cmd == CMD_START) begin
                  tp_in = p_sat;
                  for (int k = 0; k < MAX_VARS; k++) begin
                     part_in[k] = (k == 0) ? p_sat : '0;
                  end
                  coef_in  = fact_value(p_sat);
                  i_in     = '0;
                  fin_in   = 1'b0;
                  first_in = 1'b1;
                  state_in = S_LOAD;
               end else if (fin_ff) begin
                  out_v_in = 1'b1;
                  res_in   = 1'b0;
                  ocoef_in = '0;
                  oexp_in  = '0;
                  last_in  = 1'b0;
               end else begin
                  pcoef_in = coef_ff[CoefW-1:0];
                  pexp_in  = cur_exp;
                  j_in     = last_idx;
                  state_in = S_FIND;
               end
            end
         end
         S_FIND: begin
            if (j_ff == '0) begin
               j_in     = last_idx;
               rest_in  = '0;
               state_in = S_PART;
            end else if (perm_ff[j_ff - IW'(1)] > perm_ff[j_ff]) begin
               i_in     = j_ff - IW'(1);
               j_in     = last_idx;
               state_in = S_SWAP;
            end else begin
               j_in = j_ff - IW'(1);
            end
         end
         S_SWAP: begin
            if (perm_ff[j_ff] < perm_ff[i_ff]) begin
               perm_in[i_ff] = perm_ff[j_ff];
               perm_in[j_ff] = perm_ff[i_ff];
               lo_in    = i_ff + IW'(1);
               hi_in    = last_idx;
               state_in = S_REV;
            end else begin
               j_in = j_ff - IW'(1);
            end
         end
         S_REV: begin
            if (lo_ff < hi_ff) begin
               perm_in[lo_ff] = perm_ff[hi_ff];
               perm_in[hi_ff] = perm_ff[lo_ff];
               lo_in = lo_ff + IW'(1);
               hi_in = hi_ff - IW'(1);
            end else begin
               state_in = S_IDLE;
               out_v_in = 1'b1;
               res_in   = 1'b1;
               ocoef_in = pcoef_ff;
               oexp_in  = pexp_ff;
               last_in  = 1'b0;
            end
         end
         S_PART: begin
            if (part_ff[j_ff] != '0 && prod >= PW'(r)) begin
               part_in[j_ff] = v;
               for (int k = 0; k < MAX_VARS; k++) begin
                  if (k > int'(j_ff) && k < int'(nv_ff)) begin
                     take       = (r > v) ? v : r;
                     part_in[k] = take;
                     r          = r - take;
                  end
               end
               coef_in  = fact_value(tp_ff);
               i_in     = '0;
               state_in = S_LOAD;
            end else if (j_ff == '0) begin
               fin_in   = 1'b1;
               state_in = S_IDLE;
               out_v_in = 1'b1;
               res_in   = 1'b1;
               ocoef_in = pcoef_ff;
               oexp_in  = pexp_ff;
               last_in  = 1'b1;
            end else begin
               rest_in = rest_ff + part_ff[j_ff];
               j_in    = j_ff - IW'(1);
            end
         end
         S_LOAD: begin
            perm_in[i_ff] = part_ff[i_ff];
            dv_start      = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!dv_busy) begin
               coef_in = dv_quo;
               if (i_ff == last_idx) begin
                  if (first_ff) begin
                     // The first term of a new expansion is known only now.
                     first_in = 1'b0;
                     pcoef_in = dv_quo[CoefW-1:0];
                     pexp_in  = cur_exp;
                     j_in     = last_idx;
                     state_in = S_FIND;
                  end else begin
                     state_in = S_IDLE;
                     out_v_in = 1'b1;
                     res_in   = 1'b1;
                     ocoef_in = pcoef_ff;
                     oexp_in  = pexp_ff;
                     last_in  = 1'b0;
                  end
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = S_LOAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_write) begin
         nv_in  = nv_sat;
         fin_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nv_ff    <= NW'(2);
         fin_ff   <= 1'b1;
         first_ff <= 1'b0;
         out_v_ff <= 1'b0;
         res_ff   <= 1'b0;
         last_ff  <= 1'b0;
         ocoef_ff <= '0;
         oexp_ff  <= '0;
         tp_ff    <= '0;
         coef_ff  <= '0;
         for (int k = 0; k < MAX_VARS; k++) begin
            part_ff[k] <= '0;
            perm_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         nv_ff    <= nv_in;
         fin_ff   <= fin_in;
         first_ff <= first_in;
         out_v_ff <= out_v_in;
         res_ff   <= res_in;
         last_ff  <= last_in;
         ocoef_ff <= ocoef_in;
         oexp_ff  <= oexp_in;
         tp_ff    <= tp_in;
         coef_ff  <= coef_in;
         part_ff  <= part_in;
         perm_ff  <= perm_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      rest_ff  <= rest_in;
      pcoef_ff <= pcoef_in;
      pexp_ff  <= pexp_in;
   end
endmodule
`default_nettype wire

/* rtl/mte_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on mte_pkg.
`default_nettype none
module mte_divider
   import mte_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [FactW-1:0] dividend,
   input  wire logic [FactW-1:0] divisor,
   output logic                  busy,
   output logic [FactW-1:0]      quotient
);
   logic [FactW-1:0] quo_ff, quo_in, rem_ff, rem_in, div_ff, div_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic [FactW:0]   trial;

   assign busy     = (cnt_ff != 7'd0);
   assign quotient = quo_ff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[FactW-1]} - {1'b0, div_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = 7'(FactW);
      end else if (busy) begin
         cnt_in = cnt_ff - 7'd1;
         if (!trial[FactW]) begin
            rem_in = trial[FactW-1:0];
            quo_in = {quo_ff[FactW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[FactW-2:0], quo_ff[FactW-1]};
            quo_in = {quo_ff[FactW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end
endmodule
`default_nettype wire

/* rtl/mte_checker.sv */
// Port-level checks for the multinomial term enumerator, bound to the top level.
// Depends on mte_pkg.
`default_nettype none
module mte_checker
   import mte_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic             rsp_valid_res,
   input wire logic [CoefW-1:0] rsp_coefficient,
   input wire logic [ExpW-1:0]  rsp_exponents,
   input wire logic             rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_valid_res, rsp_coefficient, rsp_exponents, rsp_last}))
      else $error("result changed while stalled");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         rsp_coefficient == '0 && rsp_exponents == '0 && !rsp_last)
      else $error("empty result carries data");
   a_term_coef: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_coefficient != '0)
      else $error("term with zero coefficient");
   a_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result blocked");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request withdrawn while stalled");
endmodule

bind multinomial_term_enumerator mte_checker u_mte_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_valid_res(rsp_valid_res),
   .rsp_coefficient(rsp_coefficient), .rsp_exponents(rsp_exponents),
   .rsp_last(rsp_last)
);
`default_nettype wire

/* tb/tb_multinomial_term_enumerator.sv */
// Testbench for multinomial_term_enumerator: drives start and next transactions and
// checks every term against a predictor of the enumeration. Depends on mte_pkg and the RTL.
`default_nettype none
module tb_multinomial_term_enumerator
   import mte_pkg::*;
();

   typedef struct {
      bit        has_term;
      bit [23:0] coef;
      bit [15:0] expo;
      bit        last;
   } term_type;

   class term_scoreboard;
      int unsigned nv = 2;
      int unsigned parts[4];
      int unsigned perm[4];
      int unsigned tot;
      longint unsigned coef;
      bit fin = 1;
      term_type pending[$];
      int errors;
      int checked;

      function longint unsigned factorial(int unsigned k);
         longint unsigned r;
         r = 1;
         for (int unsigned i = 2; i <= k; i++) begin
            r = r * i;
         end
         return r;
      endfunction

      function void set_vars(bit [2:0] v);
         nv = (v < 2) ? 2 : (v > 4) ? 4 : v;
         fin = 1;
      endfunction

      function void load_partition();
         longint unsigned c;
         c = factorial(tot);
         for (int unsigned i = 0; i < nv; i++) begin
            perm[i] = parts[i];
            c = c / factorial(parts[i]);
         end
         coef = c;
      endfunction

      function bit prev_arrangement();
         int i, j, lo, hi;
         int unsigned t;
         bit found;
         found = 0;
         i = 0;
         for (j = nv - 1; j > 0; j--) begin
            if (perm[j-1] > perm[j]) begin
               i = j - 1;
               found = 1;
               break;
            end
         end
         if (!found) return 0;
         for (j = nv - 1; j > i; j--) begin
            if (perm[j] < perm[i]) break;
         end
         t = perm[i]; perm[i] = perm[j]; perm[j] = t;
         lo = i + 1;
         hi = nv - 1;
         while (lo < hi) begin
            t = perm[lo]; perm[lo] = perm[hi]; perm[hi] = t;
            lo++;
            hi--;
         end
         return 1;
      endfunction

      function bit next_partition();
         int unsigned rest, v, r, take;
         rest = 0;
         for (int p = nv - 1; p >= 0; p--) begin
            if (parts[p] != 0) begin
               v = parts[p] - 1;
               r = rest + 1;
               if (v * (nv - 1 - p) >= r) begin
                  parts[p] = v;
                  for (int j = p + 1; j < nv; j++) begin
                     take = (r > v) ? v : r;
                     parts[j] = take;
                     r -= take;
                  end
                  return 1;
               end
            end
            rest += parts[p];
         end
         return 0;
      endfunction

      function void note_request(bit cmd, bit [3:0] power);
         term_type t;
         t = '{default: 0};
         if (cmd == CMD_START) begin
            tot = power;
            parts = '{default: 0};
            parts[0] = power;
            load_partition();
            fin = 0;
         end else if (fin) begin
            pending.push_back(t);
            return;
         end
         t.has_term = 1;
         t.coef = coef[23:0];
         for (int unsigned i = 0; i < nv; i++) begin
            t.expo[4*i +: 4] = perm[i][3:0];
         end
         if (!prev_arrangement()) begin
            if (next_partition()) load_partition();
            else fin = 1;
         end
         t.last = fin;
         pending.push_back(t);
      endfunction

      function void check_response(term_type got);
         term_type exp_t;
         checked++;
         if (pending.size() == 0) begin
            $error("result with no transaction outstanding");
            errors++;
            return;
         end
         exp_t = pending.pop_front();
         if (got.has_term !== exp_t.has_term) begin
            $error("valid_res: expected %0d, got %0d", exp_t.has_term, got.has_term);
            errors++;
         end
         if (got.coef !== exp_t.coef) begin
            $error("coefficient: expected %0d, got %0d", exp_t.coef, got.coef);
            errors++;
         end
         if (got.expo !== exp_t.expo) begin
            $error("exponents: expected %h, got %h", exp_t.expo, got.expo);
            errors++;
         end
         if (got.last !== exp_t.last) begin
            $error("last: expected %0d, got %0d", exp_t.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_cmd = 0;
   logic [3:0] req_power = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_valid_res;
   logic [CoefW-1:0] rsp_coefficient;
   logic [ExpW-1:0] rsp_exponents;
   logic rsp_last;
   logic csr_write = 0;
   logic [2:0] csr_data = 0;

   term_scoreboard sb = new();
   int sent;
   int cfg_writes;
   bit no_gaps;

   multinomial_term_enumerator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_power(req_power),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_valid_res(rsp_valid_res), .rsp_coefficient(rsp_coefficient),
      .rsp_exponents(rsp_exponents), .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: checks each accepted result and may then stall at random, unless no_gaps is set.
   initial begin
      int unsigned hold;
      term_type got;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.has_term = rsp_valid_res;
            got.coef = rsp_coefficient;
            got.expo = rsp_exponents;
            got.last = rsp_last;
            sb.check_response(got);
            hold = no_gaps ? 0 : $urandom_range(0, 8);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   task automatic send(bit cmd, bit [3:0] power);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_power <= power;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, power);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_vars(bit [2:0] v);
      drain();
      csr_write <= 1;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      sb.set_vars(v);
      cfg_writes++;
   endtask

   task automatic run_expansion(bit [3:0] power, int unsigned extra);
      send(CMD_START, power);
      while (!sb.fin) send(CMD_NEXT, 4'($urandom));
      repeat (extra) send(CMD_NEXT, 4'($urandom));
   endtask

   initial begin
      bit [2:0] settings[8];
      int phase, budget, kind, n;
      bit [3:0] p;
      settings = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Next before any start, then power zero and the largest power with two variables.
      send(CMD_NEXT, 4'd0);
      send(CMD_START, 4'd0);
      send(CMD_NEXT, 4'd9);
      run_expansion(4'd15, 1);

      phase = 0;
      while (sent < 1850) begin
         write_vars(phase < 8 ? settings[phase] : 3'($urandom));
         no_gaps = (phase % 3 == 2);
         budget = (sent + 200 < 1850) ? sent + 200 : 1850;
         while (sent < budget) begin
            p = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5));
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               run_expansion(4'($urandom_range(0, 5)), $urandom_range(0, 2));
            end else if (kind < 9) begin
               send(CMD_START, p);
               n = $urandom_range(0, 6);
               repeat (n) send(CMD_NEXT, 4'($urandom));
            end else begin
               send(1'($urandom), 4'($urandom));
            end
            if (phase == 1 && sent > budget - 100 && sent < budget - 90) drain();
         end
         phase++;
      end

      drain();
      $display("Sent %0d transactions over %0d num_vars writes; %0d results checked.",
               sent, cfg_writes, sb.checked);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
rtl/mte_pkg.sv
rtl/mte_divider.sv
rtl/multinomial_term_enumerator.sv
rtl/mte_checker.sv
tb/tb_multinomial_term_enumerator.sv
